>>> rtl/core/rsbg_pkg.sv
package rsbg_pkg;

    // field widths
    localparam int IN_W   = 41;
    localparam int LEN_W  = 40;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 3;

    typedef logic [LEN_W-1:0]  t_frame;
    typedef logic [STAT_W-1:0] t_status;

    // result status codes
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BAD_RANGE   = 3'd1;
    localparam t_status ST_AMT_NONPOS  = 3'd2;
    localparam t_status ST_AMT_TOO_BIG = 3'd3;
    localparam t_status ST_TOO_MANY    = 3'd4;

    // divider results back to the sequencer
    typedef struct packed {
        logic   done;
        t_frame quot;
        t_frame rem;
    } t_div_rsp;

endpackage

>>> rtl/core/rsbg_if.sv
// request channel
interface rsbg_req_if;
    import rsbg_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic signed [IN_W-1:0] range_start;
    logic signed [IN_W-1:0] range_end;
    logic signed [IN_W-1:0] amount;
    logic                   tail_policy;

    modport source (
        output valid, op, range_start, range_end, amount, tail_policy,
        input  ready
    );
    modport sink (
        input  valid, op, range_start, range_end, amount, tail_policy,
        output ready
    );
endinterface

// result channel
interface rsbg_rsp_if;
    import rsbg_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slice_index;
    logic [LEN_W-1:0]  slice_start;
    logic [LEN_W-1:0]  slice_end;
    logic              last;

    modport source (
        output valid, status, slice_index, slice_start, slice_end, last,
        input  ready
    );
    modport sink (
        input  valid, status, slice_index, slice_start, slice_end, last,
        output ready
    );
endinterface

>>> rtl/core/rsbg_div.sv
module rsbg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rsbg_pkg::t_frame   i_dividend,
    input  rsbg_pkg::t_frame   i_divisor,
    output rsbg_pkg::t_div_rsp o_rsp
);
    import rsbg_pkg::*;

    localparam int STEP_W = $clog2(LEN_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_frame            r_rem;
    t_frame            r_quo;
    t_frame            r_dvs;

    logic [LEN_W:0] trial;
    logic [LEN_W:0] diff;
    logic           ge;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign trial = {r_rem, r_quo[LEN_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(LEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_quo <= {r_quo[LEN_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

>>> rtl/core/range_slice_boundary_generator_top.sv
// a valid request steps through the check and limit states, the serial divide and the count
// state; the emit state then puts its first word in the output register, then one slice word per
// cycle while the sink takes them; a new request is taken only once its last word is emitted
// a rejected request gives its single error word from the check or limit state, or from the
// count state after the divide for a fixed-length slice count over the limit
// reset: synchronous active low, clears the sequencer and the output valid
module range_slice_boundary_generator_top #(
    parameter int MAX_SLICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsbg_req_if.sink    i_req,
    rsbg_rsp_if.source  o_rsp
);
    import rsbg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LIMIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_COUNT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // control
    logic [2:0]       r_state, n_state;
    logic             r_out_valid;

    // request and run payload
    logic             r_op;
    logic             r_discard;
    logic signed [IN_W-1:0] r_rs, r_re, r_am;
    t_frame           r_len;
    t_frame           r_prev;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_acc;

    // output word
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_frame           r_start, n_start;
    t_frame           r_end, n_end;
    logic             r_last, n_last;

    t_div_rsp         div_rsp;
    logic             div_go;
    logic             out_free;
    logic             err;
    t_status          err_status;
    logic             emit;
    logic             count_init;

    logic signed [IN_W-1:0] len_full;
    logic             bad_range, am_nonpos, too_big, eq_many, tail, fixed_many;
    logic [CNT_W-1:0] amt7, rem7, sum_r, quot7;
    logic             cy;
    logic             is_last;
    logic             tail_step;
    t_frame           addend;
    t_frame           next_b;

    assign out_free = !r_out_valid || o_rsp.ready;

    // request checks
    assign len_full  = r_re - r_rs;
    assign bad_range = r_rs[IN_W-1] || (r_rs >= r_re);
    assign am_nonpos = r_am[IN_W-1] || (r_am == '0);
    assign too_big   = r_am[LEN_W-1:0] > r_len;
    assign eq_many   = !r_op && (r_am[LEN_W-1:0] > LEN_W'(MAX_SLICES));

    // fixed mode slice count limit
    assign tail       = (div_rsp.rem != '0) && !r_discard;
    assign fixed_many = (div_rsp.quot > LEN_W'(MAX_SLICES))
                     || ((div_rsp.quot == LEN_W'(MAX_SLICES)) && tail);

    // boundary step: equal mode adds quot plus carry of the running remainder, fixed mode adds amount
    assign amt7      = r_am[CNT_W-1:0];
    assign rem7      = div_rsp.rem[CNT_W-1:0];
    assign quot7     = div_rsp.quot[CNT_W-1:0];
    assign sum_r     = r_acc + rem7;
    assign cy        = !r_op && (sum_r >= amt7);
    assign addend    = r_op ? r_am[LEN_W-1:0] : div_rsp.quot;
    assign tail_step = r_op && (r_k == quot7);
    assign next_b    = tail_step ? r_re[LEN_W-1:0] : r_prev + addend + LEN_W'(cy);
    assign is_last   = (r_k + CNT_W'(1)) == r_cnt;

    rsbg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_len),
        .i_divisor  (r_am[LEN_W-1:0]),
        .o_rsp      (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        err        = 1'b0;
        err_status = ST_OK;
        div_go     = 1'b0;
        count_init = 1'b0;
        emit       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (bad_range || am_nonpos) begin
                    if (out_free) begin
                        err        = 1'b1;
                        err_status = bad_range ? ST_BAD_RANGE : ST_AMT_NONPOS;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_LIMIT;
                end
            end
            S_LIMIT: begin
                if (too_big || eq_many) begin
                    if (out_free) begin
                        err        = 1'b1;
                        err_status = too_big ? ST_AMT_TOO_BIG : ST_TOO_MANY;
                        n_state    = S_IDLE;
                    end
                end else begin
                    div_go  = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) n_state = S_COUNT;
            end
            S_COUNT: begin
                if (r_op && fixed_many) begin
                    if (out_free) begin
                        err        = 1'b1;
                        err_status = ST_TOO_MANY;
                        n_state    = S_IDLE;
                    end
                end else begin
                    count_init = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (is_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // next output word
    always_comb begin
        if (err) begin
            n_status = err_status;
            n_idx    = '0;
            n_start  = '0;
            n_end    = '0;
            n_last   = 1'b1;
        end else begin
            n_status = ST_OK;
            n_idx    = r_k[IDX_W-1:0];
            n_start  = r_prev;
            n_end    = next_b;
            n_last   = is_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (err || emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and run state
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op      <= i_req.op;
            r_discard <= i_req.tail_policy;
            r_rs      <= i_req.range_start;
            r_re      <= i_req.range_end;
            r_am      <= i_req.amount;
        end
        if (r_state == S_CHECK) begin
            r_len <= len_full[LEN_W-1:0];
        end
        if (count_init) begin
            r_cnt  <= r_op ? quot7 + CNT_W'(tail) : amt7;
            r_k    <= '0;
            r_acc  <= '0;
            r_prev <= r_rs[LEN_W-1:0];
        end else if (emit) begin
            r_k    <= r_k + CNT_W'(1);
            r_acc  <= cy ? sum_r - amt7 : sum_r;
            r_prev <= next_b;
        end
        if (err || emit) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_start  <= n_start;
            r_end    <= n_end;
            r_last   <= n_last;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.slice_index = r_idx;
    assign o_rsp.slice_start = r_start;
    assign o_rsp.slice_end   = r_end;
    assign o_rsp.last        = r_last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rsbg_pkg::*;

    localparam int     MAX_SLICES  = 64;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     HOLD_CYCLES = 400;
    localparam longint FRAME_MAX   = (64'd1 << LEN_W) - 1;

    // request codes
    localparam logic OP_EQUAL     = 1'b0;
    localparam logic OP_FIXED     = 1'b1;
    localparam logic TAIL_INCLUDE = 1'b0;
    localparam logic TAIL_DISCARD = 1'b1;

    typedef struct packed {
        logic                   op;
        logic signed [IN_W-1:0] range_start;
        logic signed [IN_W-1:0] range_end;
        logic signed [IN_W-1:0] amount;
        logic                   tail_policy;
    } t_slice_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slice_index;
        logic [LEN_W-1:0]  slice_start;
        logic [LEN_W-1:0]  slice_end;
        logic              last;
    } t_slice_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsbg_req_if req();
    rsbg_rsp_if rsp();

    range_slice_boundary_generator_top #(
        .MAX_SLICES(MAX_SLICES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    t_slice_word expected_slices[$];
    t_slice_word got_word;
    t_slice_word want_word;
    int          mismatches   = 0;
    int          cycles       = 0;
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_req     = 1'b0;
    bit          hold_taken   = 1'b0;
    int          hold_left    = 0;
    int          stall_left   = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // boundary predictor
    function automatic void push_word(t_status st, int idx, longint s, longint e, bit last);
        t_slice_word w;
        w.status      = st;
        w.slice_index = idx[IDX_W-1:0];
        w.slice_start = s[LEN_W-1:0];
        w.slice_end   = e[LEN_W-1:0];
        w.last        = last;
        expected_slices = {expected_slices, w};
    endfunction

    function automatic void predict_slices(t_slice_req r);
        longint s, e, a, len, whole, rem, cnt, prev, nxt;
        s = longint'($signed(r.range_start));
        e = longint'($signed(r.range_end));
        a = longint'($signed(r.amount));
        if (s < 0 || s >= e) begin
            push_word(ST_BAD_RANGE, 0, 0, 0, 1'b1);
            return;
        end
        if (a <= 0) begin
            push_word(ST_AMT_NONPOS, 0, 0, 0, 1'b1);
            return;
        end
        len = e - s;
        if (a > len) begin
            push_word(ST_AMT_TOO_BIG, 0, 0, 0, 1'b1);
            return;
        end
        prev = s;
        if (r.op == OP_EQUAL) begin
            if (a > MAX_SLICES) begin
                push_word(ST_TOO_MANY, 0, 0, 0, 1'b1);
                return;
            end
            for (longint k = 0; k < a; k++) begin
                nxt = s + ((k + 1) * len) / a;
                push_word(ST_OK, int'(k), prev, nxt, k + 1 == a);
                prev = nxt;
            end
        end else begin
            whole = len / a;
            rem   = len % a;
            cnt   = whole + ((rem != 0 && r.tail_policy == TAIL_INCLUDE) ? 1 : 0);
            if (cnt > MAX_SLICES) begin
                push_word(ST_TOO_MANY, 0, 0, 0, 1'b1);
                return;
            end
            for (longint k = 0; k < cnt; k++) begin
                nxt = (k < whole) ? prev + a : s + len;
                push_word(ST_OK, int'(k), prev, nxt, k + 1 == cnt);
                prev = nxt;
            end
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got_word.status      = rsp.status;
            got_word.slice_index = rsp.slice_index;
            got_word.slice_start = rsp.slice_start;
            got_word.slice_end   = rsp.slice_end;
            got_word.last        = rsp.last;
            if (expected_slices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d index %0d start %0h end %0h last %0b",
                             got_word.status, got_word.slice_index, got_word.slice_start,
                             got_word.slice_end, got_word.last);
            end else begin
                want_word = expected_slices.pop_front();
                if (got_word.status !== want_word.status ||
                    got_word.slice_index !== want_word.slice_index ||
                    got_word.slice_start !== want_word.slice_start ||
                    got_word.slice_end !== want_word.slice_end ||
                    got_word.last !== want_word.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0h/%0h/%0b got %0d/%0d/%0h/%0h/%0b",
                                 want_word.status, want_word.slice_index,
                                 want_word.slice_start, want_word.slice_end, want_word.last,
                                 got_word.status, got_word.slice_index,
                                 got_word.slice_start, got_word.slice_end, got_word.last);
                end
            end
        end
    end

    // receiver: random stall bursts and one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    // random helpers
    function automatic longint rand_bits(int b);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return longint'(v & ((64'd1 << b) - 1));
    endfunction

    function automatic t_slice_req mk_req(logic op, longint rs, longint re, longint amt,
                                          logic tp);
        t_slice_req r;
        r.op          = op;
        r.range_start = rs[IN_W-1:0];
        r.range_end   = re[IN_W-1:0];
        r.amount      = amt[IN_W-1:0];
        r.tail_policy = tp;
        return r;
    endfunction

    // well-formed request with random content
    function automatic t_slice_req make_good_request();
        logic   op, tp;
        longint cnt, amt, len, rem, s, amt_max;
        int     b;
        op  = 1'($urandom_range(0, 1));
        tp  = 1'($urandom_range(0, 1));
        cnt = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(1, MAX_SLICES))
                                          : longint'($urandom_range(1, 8));
        b   = $urandom_range(0, LEN_W);
        if (op == OP_EQUAL) begin
            amt = cnt;
            len = rand_bits(b);
            if (len < amt)
                len = amt + rand_bits(4);
        end else begin
            amt_max = FRAME_MAX / (cnt + 1);
            amt     = rand_bits(b) % amt_max + 1;
            rem     = ($urandom_range(0, 2) == 0) ? 0 : rand_bits(LEN_W) % amt;
            len     = cnt * amt + rem;
        end
        s = rand_bits($urandom_range(0, LEN_W)) % (FRAME_MAX - len + 1);
        return mk_req(op, s, s + len, amt, tp);
    endfunction

    // well-formed request made to fail one check
    function automatic t_slice_req make_broken_request();
        t_slice_req r;
        longint     s, e, a;
        r = make_good_request();
        s = longint'($signed(r.range_start));
        e = longint'($signed(r.range_end));
        a = longint'($signed(r.amount));
        case ($urandom_range(0, 5))
            0: s = -(1 + rand_bits($urandom_range(0, LEN_W)));
            1: e = s - rand_bits(8);
            2: a = 0;
            3: a = -(1 + rand_bits($urandom_range(0, LEN_W)));
            4: a = e - s + 1 + rand_bits($urandom_range(0, 8));
            default: begin
                r.op = OP_EQUAL;
                s    = rand_bits(30);
                a    = MAX_SLICES + 1 + rand_bits(6);
                e    = s + a + rand_bits(10);
            end
        endcase
        return mk_req(r.op, s, e, a, r.tail_policy);
    endfunction

    function automatic t_slice_req make_noise_request();
        return mk_req(1'($urandom_range(0, 1)), rand_bits(IN_W), rand_bits(IN_W),
                      rand_bits(IN_W), 1'($urandom_range(0, 1)));
    endfunction

    // send one request word, entered and left at a falling edge
    task automatic send_request(t_slice_req r);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.valid       <= 1'b1;
        req.op          <= r.op;
        req.range_start <= r.range_start;
        req.range_end   <= r.range_end;
        req.amount      <= r.amount;
        req.tail_policy <= r.tail_policy;
        @(posedge i_clk);
        while (!req.ready)
            @(posedge i_clk);
        predict_slices(r);
        @(negedge i_clk);
    endtask

    // rejected requests, several for each check
    task automatic test_bad_requests();
        send_request(mk_req(OP_EQUAL, -1, 10, 2, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, -(FRAME_MAX + 1), FRAME_MAX, 1, TAIL_DISCARD));
        send_request(mk_req(OP_EQUAL, 5, 5, 1, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 9, 3, 1, TAIL_INCLUDE));
        send_request(mk_req(OP_EQUAL, 0, 100, 0, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 0, 100, -1, TAIL_DISCARD));
        send_request(mk_req(OP_EQUAL, 0, 100, -(FRAME_MAX + 1), TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 10, 20, 11, TAIL_INCLUDE));
        send_request(mk_req(OP_EQUAL, 0, FRAME_MAX - 1, FRAME_MAX, TAIL_DISCARD));
        send_request(mk_req(OP_EQUAL, 0, 100, MAX_SLICES + 1, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 0, MAX_SLICES + 1, 1, TAIL_INCLUDE));
        // included tail pushes the count one past the maximum
        send_request(mk_req(OP_FIXED, 0, MAX_SLICES * 3 + 1, 3, TAIL_INCLUDE));
    endtask

    // equal-count splits
    task automatic test_equal_split();
        send_request(mk_req(OP_EQUAL, FRAME_MAX - 1, FRAME_MAX, 1, TAIL_INCLUDE));
        send_request(mk_req(OP_EQUAL, 0, FRAME_MAX, MAX_SLICES, TAIL_DISCARD));
        send_request(mk_req(OP_EQUAL, 1000, 1100, 7, TAIL_INCLUDE));
        send_request(mk_req(OP_EQUAL, 0, MAX_SLICES, MAX_SLICES, TAIL_INCLUDE));
    endtask

    // fixed-length splits: exact fit, kept tail, dropped tail
    task automatic test_fixed_split();
        send_request(mk_req(OP_FIXED, 0, MAX_SLICES * 3 + 1, 3, TAIL_DISCARD));
        send_request(mk_req(OP_FIXED, 100, 112, 4, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 100, 112, 4, TAIL_DISCARD));
        send_request(mk_req(OP_FIXED, 7, 17, 3, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 7, 17, 3, TAIL_DISCARD));
        send_request(mk_req(OP_FIXED, 50, 60, 10, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 0, FRAME_MAX, 64'd1 << 39, TAIL_INCLUDE));
        send_request(mk_req(OP_FIXED, 0, FRAME_MAX, 64'd1 << 39, TAIL_DISCARD));
        send_request(mk_req(OP_FIXED, 0, MAX_SLICES, 1, TAIL_DISCARD));
    endtask

    // mostly well-formed requests, some broken, some noise
    task automatic test_random_traffic(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                send_request(make_good_request());
            else if (pick < 17)
                send_request(make_broken_request());
            else
                send_request(make_noise_request());
        end
    endtask

    // receiver holds off while full-size requests keep coming
    task automatic test_back_pressure();
        longint s;
        hold_req = 1'b1;
        repeat (4) begin
            s = rand_bits(30);
            send_request(mk_req(OP_EQUAL, s, s + 1000 + rand_bits(30), MAX_SLICES,
                                1'($urandom_range(0, 1))));
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream(int n);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_traffic(n);
    endtask

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        req.valid       = 1'b0;
        req.op          = OP_EQUAL;
        req.range_start = '0;
        req.range_end   = '0;
        req.amount      = '0;
        req.tail_policy = TAIL_INCLUDE;
        rsp.ready       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_requests();
        test_equal_split();
        test_fixed_split();
        test_random_traffic(110);
        test_back_pressure();
        test_steady_stream(40);

        req.valid <= 1'b0;
        while (expected_slices.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
